// ===== rtl/core/pplh_pkg.sv =====
// Package for the peak-pair landmark hasher: sizes, payload structs, register
// codes, state encoding and the controller/datapath command and status bundles.
// No dependencies.
package pplh_pkg;

  localparam int unsigned HISTORY_DEPTH   = 64;
  localparam int unsigned PEAKS_PER_FRAME = 10;

  localparam int unsigned HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned HIST_CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HIST_SW = HIST_CW + 1;
  localparam int unsigned STG_AW  = (PEAKS_PER_FRAME > 1) ? $clog2(PEAKS_PER_FRAME) : 1;
  localparam int unsigned STG_CW  = $clog2(PEAKS_PER_FRAME + 1);

  localparam int unsigned TIME_W = 40;
  localparam int unsigned FREQ_W = 13;
  localparam int unsigned AMP_W  = 10;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned SAME_W = 16;
  localparam int unsigned MS_W   = 6;
  localparam int unsigned CFG_W  = 24;

  // floor(x / 1000) == (x * RECIP_1000) >> DIV_SHIFT, exact for any 32-bit x
  localparam int unsigned RECIP_W    = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int unsigned DIV_SHIFT  = 38;
  localparam int unsigned PROD_W     = DT_W + RECIP_W;

  localparam logic [FREQ_W-1:0] MIN_FD_RST  = 13'd30;
  localparam logic [FREQ_W-1:0] MAX_FD_RST  = 13'd300;
  localparam logic [DT_W-1:0]   MAX_DT_RST  = 24'd3000000;
  localparam logic [SAME_W-1:0] SAME_DT_RST = 16'd1000;

  typedef enum logic [1:0] {
    CFG_MIN_FREQ_DELTA    = 2'd0,
    CFG_MAX_FREQ_DELTA    = 2'd1,
    CFG_MAX_TIME_DELTA_US = 2'd2,
    CFG_SAME_TIME_US      = 2'd3
  } pplh_cfg_e;

  typedef struct packed {
    logic [TIME_W-1:0] peak_time_us;
    logic [FREQ_W-1:0] peak_frequency;
    logic [AMP_W-1:0]  peak_amplitude;
    logic              frame_end;
  } pplh_in_t;

  typedef struct packed {
    logic [31:0]       hash;
    logic [TIME_W-1:0] anchor_time_us;
    logic [FREQ_W-1:0] anchor_frequency;
    logic [AMP_W-1:0]  anchor_amplitude;
    logic              last_of_run;
  } pplh_out_t;

  // One stored peak, as kept in the staging and history memories
  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]  amp;
  } pplh_peak_t;

  localparam int unsigned PEAK_W = $bits(pplh_peak_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_EMIT,
    ST_FLUSH,
    ST_STAGE,
    ST_COMMIT_RD,
    ST_COMMIT_WR
  } pplh_state_e;

  typedef struct packed {
    logic accept;       // latch the target peak, clear scan/commit indexes
    logic hist_rd;      // read history at the next scan index
    logic cmp;          // register the pair test of the read entry
    logic emit;         // turn a kept pair into the pending result
    logic idx_inc;      // advance the scan index
    logic flush;        // move the pending result out, marked last
    logic stage_wr;     // stage the target peak
    logic stg_rd;       // read staging at the commit index
    logic hist_wr;      // push the staged entry into the history ring
    logic commit_done;  // empty the staging area
  } pplh_cmd_t;

  typedef struct packed {
    logic hist_empty;
    logic scan_last;
    logic keep;
    logic pend_vld;
    logic out_free;
    logic tgt_end;
    logic commit_last;
  } pplh_sts_t;

  // Ring slot at a given distance from the oldest entry
  function automatic logic [HIST_AW-1:0] hist_slot(input logic [HIST_AW-1:0] base,
                                                   input logic [HIST_CW-1:0] offset);
    logic [HIST_SW-1:0] sum;
    sum = HIST_SW'(base) + HIST_SW'(offset);
    if (sum >= HIST_SW'(HISTORY_DEPTH)) begin
      sum = sum - HIST_SW'(HISTORY_DEPTH);
    end
    return sum[HIST_AW-1:0];
  endfunction

endpackage

// ===== rtl/core/pplh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the history ring and the frame staging area.
module pplh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pplh_ctrl.sv =====
// Sequencing state machine for the landmark hasher: scan, flush, stage, commit.
// Depends on pplh_pkg; drives the datapath through pplh_cmd_t only.
module pplh_ctrl
  import pplh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pplh_sts_t sts_i,
  output pplh_cmd_t cmd_o
);

  pplh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.hist_empty ? ST_STAGE : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.hist_rd = 1'b1;
        state_d       = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_SCAN_EMIT;
      end
      ST_SCAN_EMIT: begin
        // hold while a kept pair would displace a pending result nobody can take
        if (!(sts_i.keep && sts_i.pend_vld && !sts_i.out_free)) begin
          cmd_o.emit = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.idx_inc = 1'b1;
            cmd_o.hist_rd = 1'b1;
            state_d       = ST_SCAN_CMP;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_vld) begin
          state_d = ST_STAGE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_STAGE;
        end
      end
      ST_STAGE: begin
        cmd_o.stage_wr = 1'b1;
        state_d        = sts_i.tgt_end ? ST_COMMIT_RD : ST_IDLE;
      end
      ST_COMMIT_RD: begin
        cmd_o.stg_rd = 1'b1;
        state_d      = ST_COMMIT_WR;
      end
      ST_COMMIT_WR: begin
        cmd_o.hist_wr = 1'b1;
        if (sts_i.commit_last) begin
          cmd_o.commit_done = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          state_d = ST_COMMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pplh_dp.sv =====
// Datapath of the landmark hasher: configuration registers, target latch,
// history ring and staging memories, pair test, ms divide and result registers.
// Depends on pplh_pkg and pplh_ram.
module pplh_dp
  import pplh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  pplh_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pplh_out_t        out_data_o,
  input  pplh_cmd_t        cmd_i,
  output pplh_sts_t        sts_o
);

  // Configuration
  logic [FREQ_W-1:0] min_fd_q, max_fd_q;
  logic [DT_W-1:0]   max_dt_q;
  logic [SAME_W-1:0] same_dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_fd_q  <= MIN_FD_RST;
      max_fd_q  <= MAX_FD_RST;
      max_dt_q  <= MAX_DT_RST;
      same_dt_q <= SAME_DT_RST;
    end else if (cfg_we_i) begin
      unique case (pplh_cfg_e'(cfg_idx_i))
        CFG_MIN_FREQ_DELTA:    min_fd_q  <= cfg_wdata_i[FREQ_W-1:0];
        CFG_MAX_FREQ_DELTA:    max_fd_q  <= cfg_wdata_i[FREQ_W-1:0];
        CFG_MAX_TIME_DELTA_US: max_dt_q  <= cfg_wdata_i[DT_W-1:0];
        CFG_SAME_TIME_US:      same_dt_q <= cfg_wdata_i[SAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Target peak
  pplh_in_t tgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tgt_q <= in_data_i;
    end
  end

  // Counters and ring pointers
  logic [HIST_AW-1:0] oldest_q;
  logic [HIST_CW-1:0] hist_cnt_q;
  logic [HIST_CW-1:0] scan_idx_q, scan_idx_d;
  logic [STG_CW-1:0]  stg_cnt_q;
  logic [STG_CW-1:0]  cidx_q;
  logic               hist_full;
  logic               stg_full;
  logic [HIST_AW-1:0] push_slot;

  assign hist_full = (hist_cnt_q == HIST_CW'(HISTORY_DEPTH));
  assign stg_full  = (stg_cnt_q == STG_CW'(PEAKS_PER_FRAME));
  assign push_slot = hist_full ? oldest_q : hist_slot(oldest_q, hist_cnt_q);

  always_comb begin
    scan_idx_d = scan_idx_q;
    if (cmd_i.accept) begin
      scan_idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      scan_idx_d = scan_idx_q + HIST_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q   <= '0;
      hist_cnt_q <= '0;
      scan_idx_q <= '0;
      stg_cnt_q  <= '0;
      cidx_q     <= '0;
    end else begin
      scan_idx_q <= scan_idx_d;
      if (cmd_i.accept) begin
        cidx_q <= '0;
      end else if (cmd_i.hist_wr) begin
        cidx_q <= cidx_q + STG_CW'(1);
      end
      if (cmd_i.hist_wr) begin
        // full ring: overwrite the oldest entry and advance past it
        if (hist_full) begin
          oldest_q <= hist_slot(oldest_q, HIST_CW'(1));
        end else begin
          hist_cnt_q <= hist_cnt_q + HIST_CW'(1);
        end
      end
      if (cmd_i.commit_done) begin
        stg_cnt_q <= '0;
      end else if (cmd_i.stage_wr && !stg_full) begin
        stg_cnt_q <= stg_cnt_q + STG_CW'(1);
      end
    end
  end

  // Memories
  pplh_peak_t stg_wdata, stg_rdata, hist_rdata;

  assign stg_wdata = '{time_us: tgt_q.peak_time_us,
                       freq:    tgt_q.peak_frequency,
                       amp:     tgt_q.peak_amplitude};

  pplh_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (PEAKS_PER_FRAME)
  ) u_stg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.stage_wr && !stg_full),
    .waddr_i (stg_cnt_q[STG_AW-1:0]),
    .wdata_i (stg_wdata),
    .re_i    (cmd_i.stg_rd),
    .raddr_i (cidx_q[STG_AW-1:0]),
    .rdata_o (stg_rdata)
  );

  pplh_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_wr),
    .waddr_i (push_slot),
    .wdata_i (stg_rdata),
    .re_i    (cmd_i.hist_rd),
    .raddr_i (hist_slot(oldest_q, scan_idx_d)),
    .rdata_o (hist_rdata)
  );

  // Pair test on the entry just read
  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] dt;
  logic [FREQ_W-1:0] fd;
  logic              time_ok, freq_ok;

  assign diff = {1'b0, tgt_q.peak_time_us} - {1'b0, hist_rdata.time_us};
  assign dt   = diff[TIME_W-1:0];
  assign fd   = (tgt_q.peak_frequency >= hist_rdata.freq) ?
                (tgt_q.peak_frequency - hist_rdata.freq) :
                (hist_rdata.freq - tgt_q.peak_frequency);

  // anchor must be strictly earlier than the target
  assign time_ok = !diff[TIME_W] && (dt != '0) &&
                   (dt >= TIME_W'(same_dt_q)) && (dt <= TIME_W'(max_dt_q));
  assign freq_ok = (fd >= min_fd_q) && (fd <= max_fd_q);

  logic              keep_q;
  logic [DT_W-1:0]   dt_q;
  pplh_peak_t        anc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      keep_q <= time_ok && freq_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      dt_q  <= dt[DT_W-1:0];
      anc_q <= hist_rdata;
    end
  end

  // Milliseconds mod 64 through the reciprocal of 1000
  logic [PROD_W-1:0] prod;
  logic [MS_W-1:0]   ms;
  pplh_out_t         pair;

  assign prod = PROD_W'(dt_q) * PROD_W'(RECIP_1000);
  assign ms   = prod[DIV_SHIFT +: MS_W];

  assign pair = '{hash:             {anc_q.freq, tgt_q.peak_frequency, ms},
                  anchor_time_us:   anc_q.time_us,
                  anchor_frequency: anc_q.freq,
                  anchor_amplitude: anc_q.amp,
                  last_of_run:      1'b0};

  // Pending result: held back until the next kept pair or the end of the scan
  pplh_out_t pend_q, out_q, out_d;
  logic      pend_vld_q, out_vld_q;
  logic      out_free, load_mid, load_out;

  assign out_free = !out_vld_q || !out_stall_i;
  assign load_mid = cmd_i.emit && keep_q && pend_vld_q;
  assign load_out = load_mid || cmd_i.flush;

  always_comb begin
    out_d             = pend_q;
    out_d.last_of_run = cmd_i.flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.emit && keep_q) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && keep_q) begin
      pend_q <= pair;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Status
  assign sts_o.hist_empty  = (hist_cnt_q == '0);
  assign sts_o.scan_last   = ((scan_idx_q + HIST_CW'(1)) == hist_cnt_q);
  assign sts_o.keep        = keep_q;
  assign sts_o.pend_vld    = pend_vld_q;
  assign sts_o.out_free    = out_free;
  assign sts_o.tgt_end     = tgt_q.frame_end;
  assign sts_o.commit_last = ((cidx_q + STG_CW'(1)) == stg_cnt_q);

endmodule

// ===== rtl/core/peak_pair_landmark_hasher_top.sv =====
// Top level of the peak-pair landmark hasher.
// Depends on pplh_pkg, pplh_ctrl, pplh_dp (and pplh_ram through pplh_dp).

// Each accepted peak is paired with every history peak, oldest first; every
// pair that passes the time and frequency windows yields one transaction on
// the output, the last one of a peak flagged by last_of_run. Each entry of
// a history of up to 64 entries is read through the single read port of the
// history RAM and its pair test is registered before the divide-by-1000 and
// the result register. A peak that ends its frame then copies the staging
// area into the history ring, reading each staged peak and then writing it.
// A stalled output holds the scan only when a second kept pair is waiting
// behind an untaken one, and holds the final flush of a peak's last result
// until the output register is free. A new peak is taken once the previous
// one is fully processed; configuration writes are taken at any time but
// belong in idle periods.
module peak_pair_landmark_hasher_top
  import pplh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pplh_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pplh_out_t        out_data_o
);

  pplh_cmd_t cmd;
  pplh_sts_t sts;

  pplh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pplh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
